@@ hdl/well512_pkg.sv @@
// ----------------------------------------------------------------------------
// well512_pkg
// Shared types, constants and the microprogram of the WELL512a generator.
// ----------------------------------------------------------------------------
package well512_pkg;

    localparam int unsigned POOL_DEPTH = 16;
    localparam int unsigned PTR_W      = $clog2(POOL_DEPTH);
    localparam int unsigned WORD_W     = 32;

    localparam logic [WORD_W-1:0] TEMPER_MASK = 32'hDA44_2D24;
    localparam logic [WORD_W-1:0] SEED_MULT   = 32'd1812433253;
    localparam logic [PTR_W-1:0]  OFS_C13     = 4'd13;
    localparam logic [PTR_W-1:0]  OFS_C9      = 4'd9;
    localparam logic [PTR_W-1:0]  PTR_ONE     = 4'd1;
    localparam logic [PTR_W-1:0]  IDX_LAST    = 4'd15;

    // Command codes carried on the input tuser bit
    localparam logic CMD_SEED     = 1'b0;
    localparam logic CMD_GENERATE = 1'b1;

    // Microprogram step addresses
    typedef logic [2:0] t_step;
    localparam t_step STEP_IDLE  = 3'd0;
    localparam t_step STEP_S0    = 3'd1;
    localparam t_step STEP_S1    = 3'd2;
    localparam t_step STEP_G0    = 3'd3;
    localparam t_step STEP_G1    = 3'd4;
    localparam t_step STEP_G2    = 3'd5;
    localparam t_step STEP_G3    = 3'd6;
    localparam t_step STEP_SPARE = 3'd7;

    typedef enum logic [2:0] {
        AS_PTR   = 3'd0,
        AS_PTR13 = 3'd1,
        AS_PTR9  = 3'd2,
        AS_PTRM1 = 3'd3,
        AS_IDX   = 3'd4
    } t_addr_sel;

    typedef enum logic [1:0] {
        WD_SEED = 2'd0,
        WD_MIX  = 2'd1,
        WD_AP   = 2'd2,
        WD_NW   = 2'd3
    } t_wdata_sel;

    typedef enum logic [1:0] {
        IDX_HOLD = 2'd0,
        IDX_CLR  = 2'd1,
        IDX_INC  = 2'd2
    } t_idx_op;

    typedef enum logic [1:0] {
        J_NEXT     = 2'd0,
        J_DISPATCH = 2'd1,
        J_LOOP     = 2'd2,
        J_WAIT     = 2'd3
    } t_jump;

    // One control word
    typedef struct packed {
        t_addr_sel  rd_a_sel;
        t_addr_sel  rd_b_sel;
        logic       wr_en;
        t_addr_sel  wr_sel;
        t_wdata_sel wd_sel;
        logic       ld_b;
        logic       ld_nw;
        logic       ld_w;
        t_idx_op    idx_op;
        logic       gen_done;
        t_jump      jump;
        t_step      target;
    } t_uctl;

    // Status returned from the datapath for conditional jumps
    typedef struct packed {
        logic idx_last;
        logic out_busy;
    } t_ustat;

    // Microprogram ROM
    function automatic t_uctl ucode(input t_step s);
        t_uctl w;
        w.rd_a_sel = AS_PTR;
        w.rd_b_sel = AS_PTR13;
        w.wr_en    = 1'b0;
        w.wr_sel   = AS_IDX;
        w.wd_sel   = WD_SEED;
        w.ld_b     = 1'b0;
        w.ld_nw    = 1'b0;
        w.ld_w     = 1'b0;
        w.idx_op   = IDX_HOLD;
        w.gen_done = 1'b0;
        w.jump     = J_NEXT;
        w.target   = STEP_IDLE;
        case (s)
            STEP_S0: begin
                w.wr_en  = 1'b1;
                w.wd_sel = WD_SEED;
                w.ld_w   = 1'b1;
                w.idx_op = IDX_INC;
            end
            STEP_S1: begin
                w.wr_en  = 1'b1;
                w.wd_sel = WD_MIX;
                w.ld_w   = 1'b1;
                w.idx_op = IDX_INC;
                w.jump   = J_LOOP;
                w.target = STEP_IDLE;
            end
            STEP_G0: begin
                w.rd_a_sel = AS_PTR;
                w.rd_b_sel = AS_PTR13;
            end
            STEP_G1: begin
                w.rd_a_sel = AS_PTR9;
                w.rd_b_sel = AS_PTRM1;
                w.ld_b     = 1'b1;
            end
            STEP_G2: begin
                w.wr_en  = 1'b1;
                w.wr_sel = AS_PTR;
                w.wd_sel = WD_AP;
                w.ld_nw  = 1'b1;
            end
            STEP_G3: begin
                w.wr_en    = 1'b1;
                w.wr_sel   = AS_PTRM1;
                w.wd_sel   = WD_NW;
                w.gen_done = 1'b1;
                w.jump     = J_WAIT;
                w.target   = STEP_IDLE;
            end
            default: begin
                w.idx_op = IDX_CLR;
                w.jump   = J_DISPATCH;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

@@ hdl/well512_ram.sv @@
// ----------------------------------------------------------------------------
// well512_ram
// Generic RAM: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module well512_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_a_addr,
    input  logic [$clog2(DEPTH)-1:0] i_rd_b_addr,
    output logic [WIDTH-1:0]         o_rd_a_data,
    output logic [WIDTH-1:0]         o_rd_b_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_rd_a_addr];
        r_rd_b <= r_mem[i_rd_b_addr];
    end

    assign o_rd_a_data = r_rd_a;
    assign o_rd_b_data = r_rd_b;

endmodule

@@ hdl/well512_useq.sv @@
// ----------------------------------------------------------------------------
// well512_useq
// Microcode sequencer: step counter, ROM lookup and conditional jumps.
// ----------------------------------------------------------------------------
module well512_useq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    input  logic                 s_axis_tuser,
    output logic                 s_axis_tready,
    input  well512_pkg::t_ustat  i_stat,
    output well512_pkg::t_uctl   o_ctl
);

    well512_pkg::t_step r_upc;
    well512_pkg::t_step n_upc;
    well512_pkg::t_uctl w_ctl;

    assign w_ctl         = well512_pkg::ucode(r_upc);
    assign o_ctl         = w_ctl;
    assign s_axis_tready = (w_ctl.jump == well512_pkg::J_DISPATCH);

    always_comb begin
        n_upc = r_upc;
        case (w_ctl.jump)
            well512_pkg::J_NEXT: begin
                n_upc = well512_pkg::t_step'(r_upc + 3'd1);
            end
            well512_pkg::J_DISPATCH: begin
                if (s_axis_tvalid) begin
                    n_upc = (s_axis_tuser == well512_pkg::CMD_GENERATE) ?
                            well512_pkg::STEP_G0 : well512_pkg::STEP_S0;
                end
            end
            well512_pkg::J_LOOP: begin
                if (i_stat.idx_last) begin
                    n_upc = w_ctl.target;
                end
            end
            well512_pkg::J_WAIT: begin
                if (!i_stat.out_busy) begin
                    n_upc = w_ctl.target;
                end
            end
            default: begin
                n_upc = well512_pkg::STEP_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= well512_pkg::STEP_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

`ifndef ASSERT_OFF
    a_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=>
            (r_upc == well512_pkg::STEP_S0 || r_upc == well512_pkg::STEP_G0))
        else $error("accepted transaction did not start a routine");
    a_no_spare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_upc != well512_pkg::STEP_SPARE)
        else $error("sequencer reached the unused step");
`endif

endmodule

@@ hdl/well512_dpath.sv @@
// ----------------------------------------------------------------------------
// well512_dpath
// Datapath: pool memory, pointer, seed mixer, WELL512a mixer, output register.
// ----------------------------------------------------------------------------
module well512_dpath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  well512_pkg::t_uctl   i_ctl,
    output well512_pkg::t_ustat  o_stat,
    input  logic [31:0]          s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata
);

    localparam int unsigned PW = well512_pkg::PTR_W;
    localparam int unsigned WW = well512_pkg::WORD_W;

    logic [PW-1:0] r_ptr;
    logic [PW-1:0] r_idx;
    logic [WW-1:0] r_seed;
    logic [WW-1:0] r_w;
    logic [WW-1:0] r_b;
    logic [WW-1:0] r_nw;
    logic          r_out_valid;
    logic [WW-1:0] r_out_data;

    logic [PW-1:0] w_rd_a_addr;
    logic [PW-1:0] w_rd_b_addr;
    logic [PW-1:0] w_wr_addr;
    logic [WW-1:0] w_wr_data;
    logic [WW-1:0] w_rd_a;
    logic [WW-1:0] w_rd_b;
    logic [WW-1:0] w_x;
    logic [WW-1:0] w_mix;
    logic [WW-1:0] w_b;
    logic [WW-1:0] w_c;
    logic [WW-1:0] w_ap;
    logic [WW-1:0] w_d;
    logic [WW-1:0] w_nw;
    logic          w_busy;
    logic          w_fire;

    function automatic logic [PW-1:0] addr_of(input well512_pkg::t_addr_sel sel,
                                              input logic [PW-1:0] ptr,
                                              input logic [PW-1:0] idx);
        logic [PW-1:0] a;
        case (sel)
            well512_pkg::AS_PTR:   a = ptr;
            well512_pkg::AS_PTR13: a = PW'(ptr + well512_pkg::OFS_C13);
            well512_pkg::AS_PTR9:  a = PW'(ptr + well512_pkg::OFS_C9);
            well512_pkg::AS_PTRM1: a = PW'(ptr - well512_pkg::PTR_ONE);
            well512_pkg::AS_IDX:   a = idx;
            default:               a = ptr;
        endcase
        return a;
    endfunction

    assign w_rd_a_addr = addr_of(i_ctl.rd_a_sel, r_ptr, r_idx);
    assign w_rd_b_addr = addr_of(i_ctl.rd_b_sel, r_ptr, r_idx);
    assign w_wr_addr   = addr_of(i_ctl.wr_sel, r_ptr, r_idx);

    // Seed recurrence: xor-shift, multiply, then add the word index
    assign w_x   = r_w ^ (r_w >> 30);
    assign w_mix = WW'(well512_pkg::SEED_MULT * w_x) + WW'(r_idx);

    // First mix from word[p] and word[p+13]
    assign w_b = w_rd_a ^ w_rd_b ^ (w_rd_a << 16) ^ (w_rd_b << 15);

    // Second mix from word[p+9] and word[p-1]
    assign w_c  = w_rd_a ^ (w_rd_a >> 11);
    assign w_ap = r_b ^ w_c;
    assign w_d  = w_ap ^ ((w_ap << 5) & well512_pkg::TEMPER_MASK);
    assign w_nw = w_rd_b ^ r_b ^ w_d ^ (w_rd_b << 2) ^ (r_b << 18) ^ (w_c << 28);

    always_comb begin
        case (i_ctl.wd_sel)
            well512_pkg::WD_SEED: w_wr_data = r_seed;
            well512_pkg::WD_MIX:  w_wr_data = w_mix;
            well512_pkg::WD_AP:   w_wr_data = w_ap;
            well512_pkg::WD_NW:   w_wr_data = r_nw;
            default:              w_wr_data = r_seed;
        endcase
    end

    well512_ram #(
        .WIDTH (WW),
        .DEPTH (well512_pkg::POOL_DEPTH)
    ) u_pool (
        .i_clk       (i_clk),
        .i_wr_en     (i_ctl.wr_en),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_wr_data),
        .i_rd_a_addr (w_rd_a_addr),
        .i_rd_b_addr (w_rd_b_addr),
        .o_rd_a_data (w_rd_a),
        .o_rd_b_data (w_rd_b)
    );

    assign w_busy = r_out_valid && !m_axis_tready;
    assign w_fire = i_ctl.gen_done && !w_busy;

    assign o_stat.idx_last = (r_idx == well512_pkg::IDX_LAST);
    assign o_stat.out_busy = w_busy;

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.jump == well512_pkg::J_DISPATCH) begin
            r_seed <= s_axis_tdata;
        end
        if (i_ctl.ld_w) begin
            r_w <= w_wr_data;
        end
        if (i_ctl.ld_b) begin
            r_b <= w_b;
        end
        if (i_ctl.ld_nw) begin
            r_nw <= w_nw;
        end
        if (w_fire) begin
            r_out_data <= r_nw;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_ptr <= PW'(r_ptr - well512_pkg::PTR_ONE);
            end
            case (i_ctl.idx_op)
                well512_pkg::IDX_CLR:  r_idx <= '0;
                well512_pkg::IDX_INC:  r_idx <= PW'(r_idx + well512_pkg::PTR_ONE);
                well512_pkg::IDX_HOLD: r_idx <= r_idx;
                default:               r_idx <= r_idx;
            endcase
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    a_ptr_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> (r_out_valid && (r_ptr == PW'($past(r_ptr) - well512_pkg::PTR_ONE))))
        else $error("generate finished without loading a result and stepping the pointer");
    a_loop_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.jump == well512_pkg::J_LOOP) |-> (r_idx != '0))
        else $error("seed loop overwrote the seed word");
`endif

endmodule

@@ hdl/well512_random_generator.sv @@
// ----------------------------------------------------------------------------
// well512_random_generator
// WELL512a pseudo-random word generator, microcoded over a 16-word pool.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                               Transaction
//  s_axis    in         tuser: command  tdata: seed_value     one command
//  m_axis    out        tdata: random_word                    one word
//
//  Generate: accept, two pool read rounds and two pool writes per
//  transaction, set by the two read ports and one write port of the pool.
//  Seed: accept, seed word, fifteen recurrence steps, one word written per
//  cycle; it returns no word and leaves the pointer alone.
//  Reset clears the step counter, pointer and output valid; the pool holds
//  garbage until the first seed, so issue a seed before any generate.
//  A stalled m_axis holds the last generate step until the output register
//  frees; s_axis is taken back-to-back with a waiting result.
//
module well512_random_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] seed_value
    input  logic        s_axis_tuser,   // [0] command: 0 seed, 1 generate
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] random_word
);

    well512_pkg::t_uctl  w_ctl;
    well512_pkg::t_ustat w_stat;

    // Step through the microprogram; dispatch on command when idle
    well512_useq u_useq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tready (s_axis_tready),
        .i_stat        (w_stat),
        .o_ctl         (w_ctl)
    );

    // Hold the pool and do the arithmetic under control-word direction
    well512_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .o_stat        (w_stat),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
